/* src/pba_pkg.sv */
// Shared types and constants for the page buddy allocator.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

    localparam int SIZE_W    = 16;   // request size field
    localparam int LOG_W     = 5;    // log2 of a block size
    localparam int MIN_LOG   = 4;    // smallest block: 16 bytes
    localparam int MAX_LOG   = 17;   // clamp for a header's size field
    localparam int HDR_BYTES = 8;    // header in front of each payload
    localparam int SLOT_LOG  = 4;    // one header slot per 16 bytes
    localparam int EXT_W     = 17;   // room for 2^16 in size arithmetic
    localparam int POS_EXT_W = 18;   // room for position plus 2^17
    localparam int OFF_W     = 12;   // payload_offset field
    localparam int GSZ_W     = 12;   // granted_size field
    localparam int PIDX_W    = 2;    // page_index field
    localparam int PG_EXT_W  = 7;    // room for any page count

    typedef struct packed {
        logic             used;
        logic [LOG_W-1:0] lg;
    } pba_hdr_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_req;     // latch request, restart search
        logic class_inc;    // grow size class by one
        logic walk_start;   // start walking the current page
        logic open_page;    // open next page as one free block
        logic rd;           // read header at current position
        logic skip;         // advance past current block
        logic next_page;    // advance to next page
        logic mark;         // mark current block used
        logic split_left;   // rewrite current block as left half
        logic split_right;  // write header of right half
        logic post_ok;      // load a granted result
        logic post_fail;    // load a failure result
    } pba_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic size_bad;     // zero or too large for a page
        logic class_fits;   // current class holds the request
        logic page_avail;   // current page is an open page
        logic can_open;     // a further page may be opened
        logic opened;       // this request already opened a page
        logic hdr_skip;     // block too small or in use
        logic hdr_match;    // block size equals the class
        logic walk_end;     // next block lies past the page
        logic out_free;     // result register can be loaded
    } pba_sts_t;

endpackage

`default_nettype wire

/* src/pba_if.sv */
// Request and response channel interfaces of the page buddy allocator.
`timescale 1ns / 1ps
`default_nettype none

interface pba_req_if import pba_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] request_size;

    modport source (output valid, output request_size, input ready);
    modport sink (input valid, input request_size, output ready);
endinterface

interface pba_rsp_if import pba_pkg::*;;
    logic              valid;
    logic              ready;
    logic              granted;
    logic [PIDX_W-1:0] page_index;
    logic [OFF_W-1:0]  payload_offset;
    logic [GSZ_W-1:0]  granted_size;
    logic              opened_page;

    modport source (output valid, output granted, output page_index,
                    output payload_offset, output granted_size,
                    output opened_page, input ready);
    modport sink (input valid, input granted, input page_index,
                  input payload_offset, input granted_size,
                  input opened_page, output ready);
endinterface

`default_nettype wire

/* src/pba_ctrl.sv */
// Sequencer for size classing, first-fit header walk and block splitting.
`timescale 1ns / 1ps
`default_nettype none

module pba_ctrl import pba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  pba_sts_t sts,
    output pba_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLASS = 8'b0000_0010,
        S_PAGE  = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_EVAL  = 8'b0001_0000,
        S_SPLIT = 8'b0010_0000,
        S_OK    = 8'b0100_0000,
        S_FAIL  = 8'b1000_0000
    } pba_state_t;

    pba_state_t state_reg;
    pba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (sts.size_bad)
                begin
                    state_next = S_FAIL;
                end
                else if (!sts.class_fits)
                begin
                    cmd.class_inc = 1'b1;
                end
                else
                begin
                    state_next = S_PAGE;
                end
            end
            S_PAGE:
            begin
                if (sts.page_avail)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_RD;
                end
                else if (sts.can_open && !sts.opened)
                begin
                    cmd.open_page = 1'b1;
                    state_next    = S_RD;
                end
                else
                begin
                    state_next = S_FAIL;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.hdr_skip)
                begin
                    if (sts.walk_end)
                    begin
                        cmd.next_page = 1'b1;
                        state_next    = S_PAGE;
                    end
                    else
                    begin
                        cmd.skip   = 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (sts.hdr_match)
                begin
                    cmd.mark   = 1'b1;
                    state_next = S_OK;
                end
                else
                begin
                    cmd.split_left = 1'b1;
                    state_next     = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                // re-read the left half after both halves are written
                cmd.split_right = 1'b1;
                state_next      = S_RD;
            end
            S_OK:
            begin
                if (sts.out_free)
                begin
                    cmd.post_ok = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.post_fail = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_post_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.post_ok || cmd.post_fail) |-> sts.out_free)
        else $error("result loaded while previous result still pending");

endmodule

`default_nettype wire

/* src/pba_datapath.sv */
// Request registers, header memory, walk position and result register.
`timescale 1ns / 1ps
`default_nettype none

module pba_datapath import pba_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int NUM_PAGES  = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] request_size,
    input  pba_cmd_t          cmd,
    output pba_sts_t          sts,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              rsp_granted,
    output logic [PIDX_W-1:0] rsp_page_index,
    output logic [OFF_W-1:0]  rsp_payload_offset,
    output logic [GSZ_W-1:0]  rsp_granted_size,
    output logic              rsp_opened_page
);

    // page block is 2^PLOG bytes, PLOG = floor(log2(PAGE_BYTES + 8))
    localparam int PLOG      = $clog2(PAGE_BYTES + HDR_BYTES + 1) - 1;
    localparam int PW        = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int OW        = $clog2(NUM_PAGES + 1);
    localparam int AW        = PW + PLOG - SLOT_LOG;
    localparam int MEM_DEPTH = 1 << AW;

    localparam logic [EXT_W-1:0]     LIMIT    = EXT_W'((1 << PLOG) - HDR_BYTES);
    localparam logic [POS_EXT_W-1:0] SPAN     = POS_EXT_W'(1 << PLOG);
    localparam logic [OW-1:0]        PAGE_MAX = OW'(NUM_PAGES);
    localparam logic [LOG_W-1:0]     PAGE_LG  = LOG_W'(PLOG);

    pba_hdr_t hdr_mem [MEM_DEPTH];

    logic [SIZE_W-1:0] size_reg;
    logic [LOG_W-1:0]  class_reg;
    logic [OW-1:0]     page_reg;
    logic [PLOG-1:0]   pos_reg;
    logic [OW-1:0]     pages_open_reg;
    logic              opened_reg;
    logic              out_valid_reg;
    pba_hdr_t          hdr_reg;

    logic              out_granted_reg;
    logic [PIDX_W-1:0] out_page_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [GSZ_W-1:0]  out_gsz_reg;
    logic              out_opened_reg;

    logic [LOG_W-1:0]     lg_c;
    logic [LOG_W-1:0]     lg_half;
    logic [POS_EXT_W-1:0] pos_sum;
    logic [PLOG-1:0]      right_pos;
    logic [EXT_W-1:0]     class_bytes;
    logic [EXT_W-1:0]     off_full;
    logic [PG_EXT_W-1:0]  page_full;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    pba_hdr_t             wr_data;

    // clamp the stored size field as the walk expects
    always_comb
    begin
        if (hdr_reg.lg < LOG_W'(MIN_LOG))
        begin
            lg_c = LOG_W'(MIN_LOG);
        end
        else if (hdr_reg.lg > LOG_W'(MAX_LOG))
        begin
            lg_c = LOG_W'(MAX_LOG);
        end
        else
        begin
            lg_c = hdr_reg.lg;
        end
    end

    assign lg_half     = lg_c - LOG_W'(1);
    assign pos_sum     = POS_EXT_W'(pos_reg) + (POS_EXT_W'(1) << lg_c);
    assign right_pos   = pos_reg + (PLOG'(1) << lg_half);
    assign class_bytes = (EXT_W'(1) << class_reg) - EXT_W'(HDR_BYTES);
    assign off_full    = EXT_W'(pos_reg) + EXT_W'(HDR_BYTES);
    assign page_full   = PG_EXT_W'(page_reg);

    assign sts.size_bad   = (size_reg == '0) || (EXT_W'(size_reg) > LIMIT);
    assign sts.class_fits = (class_bytes >= EXT_W'(size_reg));
    assign sts.page_avail = (page_reg < pages_open_reg);
    assign sts.can_open   = (pages_open_reg < PAGE_MAX);
    assign sts.opened     = opened_reg;
    assign sts.hdr_skip   = (lg_c < class_reg) || hdr_reg.used;
    assign sts.hdr_match  = (lg_c == class_reg);
    assign sts.walk_end   = (pos_sum >= SPAN);
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    assign rd_addr = {page_reg[PW-1:0], pos_reg[PLOG-1:SLOT_LOG]};

    // one header write per cycle
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr;
        wr_data = hdr_reg;
        if (cmd.open_page)
        begin
            wr_en   = 1'b1;
            wr_addr = {pages_open_reg[PW-1:0], (PLOG - SLOT_LOG)'(0)};
            wr_data = '{used: 1'b0, lg: PAGE_LG};
        end
        else if (cmd.mark)
        begin
            wr_en   = 1'b1;
            wr_data = '{used: 1'b1, lg: hdr_reg.lg};
        end
        else if (cmd.split_left)
        begin
            wr_en   = 1'b1;
            wr_data = '{used: hdr_reg.used, lg: lg_half};
        end
        else if (cmd.split_right)
        begin
            wr_en   = 1'b1;
            wr_addr = {page_reg[PW-1:0], right_pos[PLOG-1:SLOT_LOG]};
            wr_data = '{used: 1'b0, lg: lg_half};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            hdr_reg <= hdr_mem[rd_addr];
        end
    end

    // search registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            size_reg  <= request_size;
            class_reg <= LOG_W'(MIN_LOG);
            page_reg  <= '0;
        end
        if (cmd.class_inc)
        begin
            class_reg <= class_reg + LOG_W'(1);
        end
        if (cmd.open_page)
        begin
            page_reg <= pages_open_reg;
            pos_reg  <= '0;
        end
        if (cmd.walk_start)
        begin
            pos_reg <= '0;
        end
        if (cmd.skip)
        begin
            pos_reg <= pos_sum[PLOG-1:0];
        end
        if (cmd.next_page)
        begin
            page_reg <= page_reg + OW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_open_reg <= '0;
            opened_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take_req)
            begin
                opened_reg <= 1'b0;
            end
            if (cmd.open_page)
            begin
                pages_open_reg <= pages_open_reg + OW'(1);
                opened_reg     <= 1'b1;
            end
            if (cmd.post_ok || cmd.post_fail)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.post_ok)
        begin
            out_granted_reg <= 1'b1;
            out_page_reg    <= page_full[PIDX_W-1:0];
            out_off_reg     <= off_full[OFF_W-1:0];
            out_gsz_reg     <= class_bytes[GSZ_W-1:0];
            out_opened_reg  <= opened_reg;
        end
        else if (cmd.post_fail)
        begin
            out_granted_reg <= 1'b0;
            out_page_reg    <= '0;
            out_off_reg     <= '0;
            out_gsz_reg     <= '0;
            out_opened_reg  <= 1'b0;
        end
    end

    assign rsp_valid          = out_valid_reg;
    assign rsp_granted        = out_granted_reg;
    assign rsp_page_index     = out_page_reg;
    assign rsp_payload_offset = out_off_reg;
    assign rsp_granted_size   = out_gsz_reg;
    assign rsp_opened_page    = out_opened_reg;

    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd && wr_en))
        else $error("header read and write in the same cycle");

    a_page_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.open_page |=> (pages_open_reg == OW'($past(pages_open_reg) + OW'(1)))
                          && (pages_open_reg <= PAGE_MAX))
        else $error("page count out of step with page opening");

    a_offset_align: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_granted) |-> (rsp_payload_offset[SLOT_LOG-1:0] == 4'd8))
        else $error("granted payload offset not slot aligned plus header");

endmodule

`default_nettype wire

/* src/page_buddy_allocator_core.sv */
// Page buddy allocator: first-fit size-class allocation over a set of pages.
//
// Usage: each request transaction on req carries request_size; the block
// answers every request with exactly one transaction on rsp (granted,
// page_index, payload_offset, granted_size, opened_page). A request of zero
// bytes, one above the page limit, or one that no page can serve gives a
// result with every field zero.
// The size class grows from the smallest until the payload fits; then each
// open page is walked in turn, or one page is opened, or the request is
// refused. A walk reads block headers in address order and splits a larger
// free block until one of the class is found. A zero or oversized request
// is refused before any walk. The header walk, one memory read per visited
// block, takes most of the time; one request is in work at a time and
// req.ready is high only between requests.
// A finished result sits in an output register; the next request is taken
// while it waits, and the search stops before its result until rsp.ready.
// Reset closes all pages; header memory needs no clearing, since a page's
// headers are written when the page is opened or a block is split.
`timescale 1ns / 1ps
`default_nettype none

module page_buddy_allocator_core import pba_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int NUM_PAGES  = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    pba_req_if.sink    req,
    pba_rsp_if.source  rsp
);

    pba_cmd_t cmd;
    pba_sts_t sts;

    pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pba_datapath #(
        .PAGE_BYTES (PAGE_BYTES),
        .NUM_PAGES  (NUM_PAGES)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .request_size       (req.request_size),
        .cmd                (cmd),
        .sts                (sts),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .rsp_granted        (rsp.granted),
        .rsp_page_index     (rsp.page_index),
        .rsp_payload_offset (rsp.payload_offset),
        .rsp_granted_size   (rsp.granted_size),
        .rsp_opened_page    (rsp.opened_page)
    );

endmodule

`default_nettype wire

/* tb/page_buddy_allocator_core_test.sv */
// Self-checking testbench for the page buddy allocator core: directed and random requests.
`timescale 1ns / 1ps

module page_buddy_allocator_core_test import pba_pkg::*;;

    localparam int PAGE_BYTES     = 4096;
    localparam int NUM_PAGES      = 4;
    localparam int SLOTS_PER_PAGE = PAGE_BYTES / 16 + 1;
    localparam int TOTAL_SLOTS    = NUM_PAGES * SLOTS_PER_PAGE;
    localparam int PAGE_LOG       = $clog2(PAGE_BYTES + HDR_BYTES + 1) - 1;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int STUCK_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic              granted;
        logic [PIDX_W-1:0] page_index;
        logic [OFF_W-1:0]  payload_offset;
        logic [GSZ_W-1:0]  granted_size;
        logic              opened_page;
    } alloc_result_t;

    typedef struct {
        logic [SIZE_W-1:0] size;
        bit                drain_first;   // wait for all results before sending
    } alloc_request_t;

    logic clk;
    logic rst_n;

    pba_req_if req_ch();
    pba_rsp_if rsp_ch();

    page_buddy_allocator_core #(
        .PAGE_BYTES(PAGE_BYTES),
        .NUM_PAGES (NUM_PAGES)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Shadow allocator state
    bit             shadow_used [TOTAL_SLOTS];
    bit [LOG_W-1:0] shadow_log  [TOTAL_SLOTS];
    int             shadow_pages_open;

    alloc_request_t request_queue[$];
    alloc_result_t  awaited_results[$];

    int error_count;
    int granted_count;
    int refused_count;
    int page_open_count;
    int stuck_cycles;

    function automatic int slot_index(input int page, input int pos);
        int s;
        s = page * SLOTS_PER_PAGE + (pos >> SLOT_LOG);
        return (s < TOTAL_SLOTS) ? s : 0;
    endfunction

    // Walk the page in address order; split the first fitting free block down to the class.
    function automatic bit first_fit(input int page, input int class_log, output int where);
        int pos;
        int s;
        int buddy;
        int lg;
        pos   = 0;
        where = 0;
        while (pos < (1 << PAGE_LOG))
        begin
            s  = slot_index(page, pos);
            lg = shadow_log[s];
            if (lg < MIN_LOG)
                lg = MIN_LOG;
            if (lg > MAX_LOG)
                lg = MAX_LOG;
            if (lg < class_log || shadow_used[s])
            begin
                pos += 1 << lg;
            end
            else if (lg == class_log)
            begin
                shadow_used[s] = 1'b1;
                where = pos;
                return 1'b1;
            end
            else
            begin
                shadow_log[s] = LOG_W'(lg - 1);
                buddy = slot_index(page, pos + (1 << (lg - 1)));
                shadow_used[buddy] = 1'b0;
                shadow_log[buddy]  = LOG_W'(lg - 1);
            end
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t predict_allocation(input logic [SIZE_W-1:0] size);
        alloc_result_t res;
        int class_log;
        int where;
        int page;
        int hit_page;
        int s;
        bit ok;
        bit opened;
        res      = '0;
        ok       = 1'b0;
        opened   = 1'b0;
        hit_page = 0;
        where    = 0;
        if (size == 0 || int'(size) > (1 << PAGE_LOG) - HDR_BYTES)
            return res;
        class_log = MIN_LOG;
        while ((1 << class_log) - HDR_BYTES < int'(size))
            class_log++;
        for (page = 0; page < shadow_pages_open && page < NUM_PAGES && !ok; page++)
        begin
            if (first_fit(page, class_log, where))
            begin
                ok       = 1'b1;
                hit_page = page;
            end
        end
        if (!ok && shadow_pages_open < NUM_PAGES)
        begin
            hit_page = shadow_pages_open;
            s = slot_index(hit_page, 0);
            shadow_used[s] = 1'b0;
            shadow_log[s]  = LOG_W'(PAGE_LOG);
            shadow_pages_open++;
            opened = 1'b1;
            ok = first_fit(hit_page, class_log, where);
        end
        if (!ok)
            return res;
        res.granted        = 1'b1;
        res.page_index     = PIDX_W'(hit_page);
        res.payload_offset = OFF_W'(where + HDR_BYTES);
        res.granted_size   = GSZ_W'((1 << class_log) - HDR_BYTES);
        res.opened_page    = opened;
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return '0;
        if (r < 12)
            return SIZE_W'($urandom_range(65535, 4089));
        if (r < 55)
            return SIZE_W'($urandom_range(8, 1));
        if (r < 75)
            return SIZE_W'($urandom_range(24, 9));
        if (r < 88)
            return SIZE_W'($urandom_range(120, 25));
        if (r < 96)
            return SIZE_W'($urandom_range(1016, 121));
        return SIZE_W'($urandom_range(4088, 1017));
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(3, 1);
        if (r < 95)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.request_size = '0;
        rsp_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request driver
    int send_gap;
    int send_calm;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.request_size <= '0;
            send_gap <= 0;
            send_calm <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
            begin
                alloc_result_t exp_res;
                exp_res = predict_allocation(req_ch.request_size);
                awaited_results.push_back(exp_res);
                if (exp_res.granted)
                    granted_count++;
                else
                    refused_count++;
                if (exp_res.opened_page)
                    page_open_count++;
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (request_queue.size() > 0 &&
                     !(request_queue[0].drain_first && awaited_results.size() > 0))
            begin
                req_ch.valid <= 1'b1;
                req_ch.request_size <= request_queue[0].size;
                void'(request_queue.pop_front());
                if (send_calm > 0)
                begin
                    send_calm <= send_calm - 1;
                    send_gap <= 0;
                end
                else if ($urandom_range(99) < 2)
                begin
                    send_calm <= $urandom_range(60, 20);
                    send_gap <= 0;
                end
                else
                    send_gap <= idle_cycles();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result monitor
    int stall_left;
    int recv_calm;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left <= 0;
            recv_calm <= 0;
        end
        else
        begin
            int next_stall;
            alloc_result_t exp_res;
            next_stall = stall_left;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with no request outstanding");
                    error_count++;
                end
                else
                begin
                    exp_res = awaited_results.pop_front();
                    check_field("granted", exp_res.granted, rsp_ch.granted);
                    check_field("page_index", exp_res.page_index, rsp_ch.page_index);
                    check_field("payload_offset", exp_res.payload_offset,
                                rsp_ch.payload_offset);
                    check_field("granted_size", exp_res.granted_size, rsp_ch.granted_size);
                    check_field("opened_page", exp_res.opened_page, rsp_ch.opened_page);
                end
                if (recv_calm > 0)
                begin
                    recv_calm <= recv_calm - 1;
                    next_stall = 0;
                end
                else if ($urandom_range(99) < 2)
                begin
                    recv_calm <= $urandom_range(60, 20);
                    next_stall = 0;
                end
                else
                    next_stall = idle_cycles();
            end
            if (next_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left <= next_stall - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left <= 0;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
            $display("** page_buddy_allocator_core: FAILED **");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        logic [SIZE_W-1:0] directed_sizes[$];
        alloc_request_t item;
        error_count = 0;
        granted_count = 0;
        refused_count = 0;
        page_open_count = 0;
        stuck_cycles = 0;
        shadow_pages_open = 0;
        for (int i = 0; i < TOTAL_SLOTS; i++)
        begin
            shadow_used[i] = 1'b0;
            shadow_log[i]  = '0;
        end

        // Zero and oversized sizes, class boundaries, page opening, then all pages
        // open with no page able to serve a full-page request
        directed_sizes = '{16'd0, 16'd65535, 16'd4089, 16'd1, 16'd8, 16'd9, 16'd24,
                           16'd25, 16'd56, 16'd57, 16'd120, 16'd121, 16'd248, 16'd249,
                           16'd1016, 16'd1017, 16'd2040, 16'd4088, 16'd4088, 16'd4088,
                           16'd4088, 16'd1, 16'd32768};
        foreach (directed_sizes[i])
        begin
            item.size = directed_sizes[i];
            item.drain_first = 1'b0;
            request_queue.push_back(item);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            item.size = random_size();
            item.drain_first = (i % 200 == 0);
            request_queue.push_back(item);
        end

        @(posedge clk);
        while (!rst_n || request_queue.size() != 0 || req_ch.valid ||
               awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d allocation requests: %0d granted, %0d refused, %0d pages opened",
                 granted_count + refused_count, granted_count, refused_count,
                 page_open_count);
        $display("Included zero and oversized sizes, every size class, and full memory");
        if (error_count == 0 && awaited_results.size() == 0)
            $display("** page_buddy_allocator_core: PASSED **");
        else
            $display("** page_buddy_allocator_core: FAILED **");
        $finish;
    end

endmodule

/* page_buddy_allocator_core.f */
src/pba_pkg.sv
src/pba_if.sv
src/pba_ctrl.sv
src/pba_datapath.sv
src/page_buddy_allocator_core.sv
tb/page_buddy_allocator_core_test.sv
